FILE: src/grid_island_bridge_distance_core_assert.svh
// Assertion macros for the shortest-bridge core.
// No dependencies; included by the top level.
`ifndef GRID_ISLAND_BRIDGE_DISTANCE_CORE_ASSERT_SVH
`define GRID_ISLAND_BRIDGE_DISTANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GIBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GIBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define GIBD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GIBD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GIBD_ASSERT_NEXT(lbl, ante, cons, msg)
`define GIBD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/gibd_pkg.sv
// Shared constants and types for the shortest-bridge core.
// No dependencies.
`default_nettype none
package gibd_pkg;
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int NR_W     = $clog2(MAX_ROWS + 1);
  localparam int NC_W     = $clog2(MAX_COLS + 1);
  localparam int CFG_W    = 7;
  localparam int DIST_W   = 12;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef logic [1:0] cell_t;
  localparam cell_t CELL_WATER = 2'd0;
  localparam cell_t CELL_LAND  = 2'd1;
  localparam cell_t CELL_SEEN  = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] cost;
  } qent_t;
endpackage
`default_nettype wire

FILE: src/grid_island_bridge_distance_core.sv
// Shortest-bridge core: cell loading, island flood fill and BFS sequencer.
// Depends on gibd_pkg, gibd_cell_mem, gibd_queue_mem and the assertion header.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------
//  cell in  | start & !busy       | land, last
//  result   | done (1-cycle)      | distance, found
//  config   | cfg_write           | cfg_index, cfg_data
//
// Cells load one per cycle. After last, busy stays high while the unloaded
// cells are cleared (one per cycle), the first land cell is scanned for
// (read, check per cell) and the search runs (pop, wait per entry; read,
// check per in-grid neighbour; read per off-grid one), paced by cell memory.
// Reset is synchronous; done is a pulse the receiver cannot stall.
`default_nettype none
`include "grid_island_bridge_distance_core_assert.svh"
module grid_island_bridge_distance_core import gibd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              land,
  input  logic              last,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              done,
  output logic [DIST_W-1:0] distance,
  output logic              found
);
  typedef enum logic [7:0] {
    S_LOAD    = 8'b00000001,
    S_CLEAR   = 8'b00000010,
    S_SCAN_RD = 8'b00000100,
    S_SCAN_CK = 8'b00001000,
    S_POP     = 8'b00010000,
    S_QWAIT   = 8'b00100000,
    S_NB_RD   = 8'b01000000,
    S_NB_CK   = 8'b10000000
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [NR_W-1:0]   nr;
  logic [NC_W-1:0]   nc;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  load_pos, p, head, tail;
  logic [ROW_W-1:0]  scan_r, nb_r;
  logic [COL_W-1:0]  scan_c, nb_c;
  logic [ADDR_W-1:0] nb_addr;
  logic              bridge;
  qent_t             cur;
  logic [1:0]        k;

  logic              nb_ok;
  logic [ROW_W-1:0]  nb_r_c;
  logic [COL_W-1:0]  nb_c_c;
  logic [ROW_W+NC_W-1:0] nb_prod;
  logic [ADDR_W-1:0] nb_pos;
  logic [DIST_W-1:0] cost_inc;

  logic              cell_we;
  logic [ADDR_W-1:0] cell_waddr, cell_raddr;
  cell_t             cell_wdata, cell_rdata;
  logic              q_we;
  qent_t             q_wdata, q_rdata;

  always_comb begin
    if (rows_q == '0) begin
      nr = NR_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      nr = NR_W'(MAX_ROWS);
    end else begin
      nr = NR_W'(rows_q);
    end
    if (cols_q == '0) begin
      nc = NC_W'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      nc = NC_W'(MAX_COLS);
    end else begin
      nc = NC_W'(cols_q);
    end
  end

  assign total    = CNT_W'(nr) * CNT_W'(nc);
  assign busy     = (state != S_LOAD);
  assign cost_inc = (cur.cost == DIST_MAX) ? cur.cost : cur.cost + 1'b1;

  always_comb begin
    nb_ok  = 1'b0;
    nb_r_c = cur.row;
    nb_c_c = cur.col;
    case (k)
      DIR_UP: begin
        nb_ok  = (cur.row != '0);
        nb_r_c = cur.row - 1'b1;
      end
      DIR_LEFT: begin
        nb_ok  = (cur.col != '0);
        nb_c_c = cur.col - 1'b1;
      end
      DIR_DOWN: begin
        nb_ok  = ((NR_W'(cur.row) + 1'b1) < nr);
        nb_r_c = cur.row + 1'b1;
      end
      DIR_RIGHT: begin
        nb_ok  = ((NC_W'(cur.col) + 1'b1) < nc);
        nb_c_c = cur.col + 1'b1;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_prod = nb_r_c * nc;
  assign nb_pos  = ADDR_W'(nb_prod + (ROW_W+NC_W)'(nb_c_c));

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = p[ADDR_W-1:0];
    cell_wdata = CELL_WATER;
    cell_raddr = p[ADDR_W-1:0];
    q_we       = 1'b0;
    q_wdata    = '{row: nb_r, col: nb_c, cost: '0};
    case (state)
      S_LOAD: begin
        cell_waddr = load_pos[ADDR_W-1:0];
        cell_wdata = land ? CELL_LAND : CELL_WATER;
        cell_we    = start && (load_pos < total);
      end
      S_CLEAR: begin
        cell_we = (p < total);
      end
      S_SCAN_CK: begin
        if (cell_rdata == CELL_LAND) begin
          cell_we    = 1'b1;
          cell_wdata = CELL_SEEN;
          q_we       = 1'b1;
          q_wdata    = '{row: scan_r, col: scan_c, cost: '0};
        end
      end
      S_NB_RD: begin
        cell_raddr = nb_pos;
      end
      S_NB_CK: begin
        cell_waddr = nb_addr;
        cell_wdata = CELL_SEEN;
        if (!bridge && cell_rdata == CELL_LAND) begin
          cell_we = 1'b1;
          q_we    = (tail < CNT_W'(CELLS));
        end else if (bridge && cell_rdata == CELL_WATER) begin
          cell_we = 1'b1;
          q_we    = (tail < CNT_W'(CELLS));
          q_wdata = '{row: nb_r, col: nb_c, cost: cost_inc};
        end
      end
      default: begin
        cell_we = 1'b0;
      end
    endcase
  end

  gibd_cell_mem u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  gibd_queue_mem u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail[ADDR_W-1:0]),
    .wdata (q_wdata),
    .raddr (head[ADDR_W-1:0]),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      rows_q   <= DIM_RESET;
      cols_q   <= DIM_RESET;
      load_pos <= '0;
      head     <= '0;
      tail     <= '0;
      done     <= 1'b0;
      found    <= 1'b0;
      distance <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS: rows_q <= cfg_data;
          REG_COLS: cols_q <= cfg_data;
          default:  rows_q <= rows_q;
        endcase
      end
      case (state)
        S_LOAD: begin
          if (start) begin
            if (load_pos < total) begin
              load_pos <= load_pos + 1'b1;
            end
            if (last) begin
              p     <= (load_pos < total) ? load_pos + 1'b1 : load_pos;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (p < total) begin
            p <= p + 1'b1;
          end else begin
            p      <= '0;
            scan_r <= '0;
            scan_c <= '0;
            state  <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (p < total) begin
            state <= S_SCAN_CK;
          end else begin
            done     <= 1'b1;
            found    <= 1'b0;
            distance <= '0;
            load_pos <= '0;
            state    <= S_LOAD;
          end
        end
        S_SCAN_CK: begin
          if (cell_rdata == CELL_LAND) begin
            head   <= '0;
            tail   <= CNT_W'(1);
            bridge <= 1'b0;
            state  <= S_POP;
          end else begin
            p <= p + 1'b1;
            if (NC_W'(scan_c) + 1'b1 == nc) begin
              scan_c <= '0;
              scan_r <= scan_r + 1'b1;
            end else begin
              scan_c <= scan_c + 1'b1;
            end
            state <= S_SCAN_RD;
          end
        end
        S_POP: begin
          if (head < tail) begin
            head  <= head + 1'b1;
            state <= S_QWAIT;
          end else if (!bridge) begin
            bridge <= 1'b1;
            head   <= '0;
          end else begin
            done     <= 1'b1;
            found    <= 1'b0;
            distance <= '0;
            load_pos <= '0;
            head     <= '0;
            tail     <= '0;
            state    <= S_LOAD;
          end
        end
        S_QWAIT: begin
          cur   <= q_rdata;
          k     <= DIR_UP;
          state <= S_NB_RD;
        end
        S_NB_RD: begin
          if (nb_ok) begin
            nb_r    <= nb_r_c;
            nb_c    <= nb_c_c;
            nb_addr <= nb_pos;
            state   <= S_NB_CK;
          end else if (k == DIR_RIGHT) begin
            state <= S_POP;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_NB_CK: begin
          if (bridge && cell_rdata == CELL_LAND) begin
            done     <= 1'b1;
            found    <= 1'b1;
            distance <= cur.cost;
            load_pos <= '0;
            head     <= '0;
            tail     <= '0;
            state    <= S_LOAD;
          end else begin
            if (q_we) begin
              tail <= tail + 1'b1;
            end
            if (k == DIR_RIGHT) begin
              state <= S_POP;
            end else begin
              k     <= k + 1'b1;
              state <= S_NB_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `GIBD_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
  `GIBD_ASSERT_IMPLY(a_done_idle, done, state == S_LOAD, "result while search still running")
  `GIBD_ASSERT_IMPLY(a_nofound_zero, done && !found, distance == '0, "distance without found")
  `GIBD_ASSERT_NEVER(a_tail_bound, tail > CNT_W'(CELLS), "queue tail past capacity")
endmodule
`default_nettype wire

FILE: src/gibd_cell_mem.sv
// Grid cell store: 2-bit code per cell, one write and one registered read port.
// Depends on gibd_pkg.
`default_nettype none
module gibd_cell_mem import gibd_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  cell_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output cell_t             rdata
);
  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/gibd_queue_mem.sv
// Frontier queue store: row, column and cost per entry, registered read.
// Depends on gibd_pkg.
`default_nettype none
module gibd_queue_mem import gibd_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  qent_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output qent_t             rdata
);
  qent_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/tb_grid_island_bridge_distance_core.sv
// Testbench for grid_island_bridge_distance_core: a directed table, then random grids.
// Results are checked against a built-in BFS predictor. Depends on gibd_pkg and the core.
`timescale 1ns / 1ps
module tb_grid_island_bridge_distance_core;
  import gibd_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int NCELLS = MAX_ROWS * MAX_COLS;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              land;
  logic              last;
  logic              cfg_write;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              done;
  logic [DIST_W-1:0] distance;
  logic              found;

  grid_island_bridge_distance_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .land(land), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .distance(distance), .found(found)
  );

  typedef struct {
    logic [DIST_W-1:0] len;
    logic              hit;
  } bridge_t;

  typedef struct {
    bit cfg;
    int r;
    int c;
    bit l;
    bit t;
    bit chk;
    int d;
    bit f;
  } dir_t;

  bridge_t     bridges_due[$];
  cell_t       grid[NCELLS];
  int          qpos[NCELLS];
  int          qcost[NCELLS];
  logic [CFG_W-1:0] cur_rows;
  logic [CFG_W-1:0] cur_cols;
  int          load_pos;
  int          errors;
  int          cycles;
  int          items;
  int          grids;
  int          bridges_seen;
  dir_t        dir_tbl[17];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0d: %s", cycles, what);
  endtask

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic bit step_to(input int pos, input int k, input int nr, input int nc,
                                 output int nb);
    int r;
    int c;
    r = pos / nc;
    c = pos % nc;
    case (k)
      DIR_UP:   r = r - 1;
      DIR_LEFT: c = c - 1;
      DIR_DOWN: r = r + 1;
      default:  c = c + 1;
    endcase
    nb = r * nc + c;
    return !(r < 0 || c < 0 || r >= nr || c >= nc);
  endfunction

  function automatic void bridge_cell(input logic l, input logic t);
    int nr;
    int nc;
    int total;
    int s;
    int head;
    int tail;
    int cur;
    int cst;
    int nb;
    int span;
    bit have;
    bit hit;
    bridge_t b;
    nr = clamp_dim(cur_rows, MAX_ROWS);
    nc = clamp_dim(cur_cols, MAX_COLS);
    total = nr * nc;
    if (load_pos < total) begin
      grid[load_pos] = l ? CELL_LAND : CELL_WATER;
      load_pos++;
    end
    if (!t) return;
    for (int p = load_pos; p < total; p++) grid[p] = CELL_WATER;
    have = 0;
    s = 0;
    for (int p = 0; p < total; p++) begin
      if (grid[p] == CELL_LAND) begin
        s = p;
        have = 1;
        break;
      end
    end
    hit = 0;
    span = 0;
    head = 0;
    tail = 0;
    if (have) begin
      grid[s] = CELL_SEEN;
      qpos[0] = s;
      qcost[0] = 0;
      tail = 1;
      while (head < tail) begin
        cur = qpos[head];
        head++;
        for (int k = 0; k < 4; k++) begin
          if (step_to(cur, k, nr, nc, nb) && grid[nb] == CELL_LAND) begin
            grid[nb] = CELL_SEEN;
            if (tail < NCELLS) begin
              qpos[tail] = nb;
              qcost[tail] = 0;
              tail++;
            end
          end
        end
      end
      head = 0;
      while (head < tail && !hit) begin
        cur = qpos[head];
        cst = qcost[head];
        head++;
        for (int k = 0; k < 4; k++) begin
          if (!step_to(cur, k, nr, nc, nb)) continue;
          if (grid[nb] == CELL_SEEN) continue;
          if (grid[nb] == CELL_LAND) begin
            span = cst;
            hit = 1;
            break;
          end
          grid[nb] = CELL_SEEN;
          if (tail < NCELLS) begin
            qpos[tail] = nb;
            qcost[tail] = cst + 1;
            tail++;
          end
        end
      end
    end
    b.hit = hit;
    b.len = hit ? ((span > DIST_MAX) ? DIST_MAX : span[DIST_W-1:0]) : '0;
    bridges_due.push_back(b);
    load_pos = 0;
    grids++;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_cell(input logic l, input logic t, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    land <= l;
    last <= t;
    do @(posedge clk); while (busy);
    items++;
    bridge_cell(l, t);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    start <= 1'b0;
    @(posedge clk);
    while (bridges_due.size() != 0 || busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data <= r;
    @(posedge clk);
    cur_rows = r;
    cfg_index <= REG_COLS;
    cfg_data <= c;
    @(posedge clk);
    cur_cols = c;
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_island_bridge_distance_core verification failed");
      $finish;
    end
    if (!rst && done) begin
      bridges_seen <= bridges_seen + 1;
      if (bridges_due.size() == 0) begin
        report("result with no transaction pending");
      end else begin
        if (distance !== bridges_due[0].len)
          report($sformatf("distance %0d, want %0d", distance, bridges_due[0].len));
        if (found !== bridges_due[0].hit)
          report($sformatf("found %0b, want %0b", found, bridges_due[0].hit));
        void'(bridges_due.pop_front());
      end
    end
  end

  initial begin
    int nr;
    int nc;
    int total;
    int n;
    int dens;
    bit burst;
    bit big;
    logic [CFG_W-1:0] r7;
    logic [CFG_W-1:0] c7;
    errors = 0;
    cycles = 0;
    items = 0;
    grids = 0;
    bridges_seen = 0;
    load_pos = 0;
    cur_rows = DIM_RESET;
    cur_cols = DIM_RESET;
    rst = 1'b1;
    start = 1'b0;
    land = 1'b0;
    last = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data = '0;
    dir_tbl = '{
      '{0, 0, 0, 0, 1, 1, 0, 0},
      '{0, 0, 0, 1, 1, 1, 0, 0},
      '{1, 1, 3, 1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 1, 1, 1, 1},
      '{1, 0, 0, 1, 0, 0, 0, 0},
      '{0, 0, 0, 1, 1, 1, 0, 0},
      '{1, 1, 5, 1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 1, 1, 3, 1},
      '{1, 127, 1, 1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 1, 1, 1, 1},
      '{1, 2, 127, 1, 0, 0, 0, 0},
      '{0, 0, 0, 1, 1, 1, 0, 0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].cfg) write_dims(CFG_W'(dir_tbl[i].r), CFG_W'(dir_tbl[i].c));
      send_cell(dir_tbl[i].l, dir_tbl[i].t, pick_gap());
      if (dir_tbl[i].chk && (bridges_due[$].len != dir_tbl[i].d ||
                             bridges_due[$].hit != dir_tbl[i].f))
        report($sformatf("directed row %0d predicts %0d/%0b", i,
                         bridges_due[$].len, bridges_due[$].hit));
    end

    // random grids: mostly small, two full-size layouts loaded partially
    n = 0;
    while (items < 1800 || n < 2) begin
      big = (n < 2) && (grids % 25 == 24);
      if (big) begin
        n++;
        r7 = (n == 1) ? 7'd64 : 7'd127;
        c7 = (n == 1) ? 7'd127 : 7'd64;
        write_dims(r7, c7);
      end else if ($urandom_range(0, 9) == 0) begin
        write_dims($urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127)),
                   7'($urandom_range(0, 127)) & 7'h07);
      end else if ($urandom_range(0, 2) != 0 || clamp_dim(cur_rows, MAX_ROWS) *
                   clamp_dim(cur_cols, MAX_COLS) > 64) begin
        write_dims(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
      end
      nr = clamp_dim(cur_rows, MAX_ROWS);
      nc = clamp_dim(cur_cols, MAX_COLS);
      total = nr * nc;
      case ($urandom_range(0, 9))
        0:       total = $urandom_range(1, total);
        1:       total = total + $urandom_range(1, 4);
        default: ;
      endcase
      if (big) total = $urandom_range(150, 300);
      dens = big ? $urandom_range(1, 3) : $urandom_range(5, 80);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < total; i++)
        send_cell($urandom_range(0, 99) < dens, i == total - 1, burst ? 0 : pick_gap());
    end
    start <= 1'b0;

    while (bridges_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d cells in %0d grids, %0d results checked", items, grids, bridges_seen);
    if (errors == 0) begin
      $display("grid_island_bridge_distance_core verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("grid_island_bridge_distance_core verification failed");
    end
    $finish;
  end
endmodule
